### rtl/core/hbpd_pkg.sv
// hbpd_pkg: shared types and constants for the bus packet deframer
// no dependencies; imported by hbpd_front, hbpd_back, the top level and hbpd_checker

package hbpd_pkg;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_GOOD = 2'd0;
  localparam logic [1:0] KIND_BAD  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  // acknowledge status codes
  localparam logic [1:0] ACK_OK   = 2'd0;
  localparam logic [1:0] ACK_NAK  = 2'd1;
  localparam logic [1:0] ACK_MISS = 2'd2;

  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h21;

  // configuration register indexes
  localparam logic REG_FILTER_ENABLE = 1'b0;
  localparam logic REG_UNIT_ADDR     = 1'b1;

  // run length field, wide enough for the largest store
  localparam int N_W = 7;

  // format templates: compared bytes start at packet byte 4
  localparam int NUM_TPL = 18;
  localparam int TPL_W   = 8;
  localparam logic [4:0] FMT_UNKNOWN = 5'd18;

  // number of leading bytes that must match, the rest are don't care
  localparam logic [0:NUM_TPL-1][2:0] TPL_LEN = '{
    3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
  };

  localparam logic [0:NUM_TPL-1][0:TPL_W-1][7:0] TPL_VAL = '{
    '{8'h05, 8'h0d, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h0d, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h0d, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h0d, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h05, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h0d, 8'h0e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h0d, 8'h8e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 8'h2d, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h2d, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 8'h2d, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h2d, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 8'h25, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h25, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 8'h2d, 8'h0e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h2d, 8'h8e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h35, 8'h03, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h35, 8'h83, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic       enable;
    logic [7:0] unit;
  } cfg_t;

  // work handed from the framer to the emitter
  typedef struct packed {
    logic [1:0]     kind;
    logic [7:0]     val;
    logic [N_W-1:0] n;
    logic [7:0]     b0;
    logic [7:0]     src;
    logic [7:0]     dst;
    logic [4:0]     fmt;
    logic [1:0]     ack;
  } desc_t;

endpackage

### rtl/core/hbpd_if.sv
// hbpd_in_if and hbpd_out_if: valid/ready channels of the deframer
// no dependencies

interface hbpd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface hbpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] byte_value;
  logic [4:0] byte_index;
  logic       last;
  logic [7:0] source_addr;
  logic [7:0] dest_addr;
  logic [4:0] format_code;
  logic [1:0] ack_status;

  modport source (output valid, event_kind, byte_value, byte_index, last, source_addr,
                  dest_addr, format_code, ack_status, input ready);
  modport sink (input valid, event_kind, byte_value, byte_index, last, source_addr,
                dest_addr, format_code, ack_status, output ready);
endinterface

### rtl/core/hbpd_ram.sv
// hbpd_ram: generic one write, one read port ram with registered read
// no dependencies

module hbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/hbpd_fifo.sv
// hbpd_fifo: short register queue between framer and emitter
// no dependencies

module hbpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/hbpd_front.sv
// hbpd_front: framer that takes bytes and idle gaps, tracks count and sum,
// classifies packets and queues runs; uses hbpd_pkg and hbpd_in_if

module hbpd_front import hbpd_pkg::*; #(
  parameter int MAX_BYTES = 20,
  parameter int MATCH_BYTES = 6,
  localparam int AW = $clog2(MAX_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  hbpd_in_if.sink       in_ch,
  input  cfg_t          cfg,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic          push,
  output desc_t         push_desc,
  input  logic          q_full,
  input  logic          run_done
);

  localparam int CW = $clog2(MAX_BYTES + 1);

  logic [CW-1:0] count, count_next;
  logic [7:0]    sum, sum_next;
  logic          skip, skip_next;
  logic          supp, supp_next;
  logic          run_wait, run_wait_next;
  logic [7:0]    b0, b0_next;
  logic [7:0]    s1, s2;
  logic [7:0]    mb [MATCH_BYTES];

  logic          accept;
  logic          wr;
  logic          room;
  logic [7:0]    c;
  logic [7:0]    sum1;
  logic [CW-1:0] cnt1;
  logic [7:0]    b0n, s1n, s2n;
  logic [7:0]    mbn [MATCH_BYTES];
  logic [7:0]    mbv [MATCH_BYTES];
  logic [8:0]    len_ext, cnt_ext;
  logic          hit_bad, hit_end;
  logic [1:0]    ack_code;
  logic [4:0]    fmt;
  logic          filt_miss;
  logic          supp1;

  assign in_ch.ready = ~q_full & ~run_wait;
  assign accept      = in_ch.valid & in_ch.ready;
  assign c           = in_ch.rx_byte;
  assign room        = (count < CW'(MAX_BYTES));
  assign wr          = accept & (in_ch.command == CMD_BYTE) & room;
  assign sum1        = sum + c;
  assign cnt1        = room ? count + 1'b1 : count;

  assign we    = wr;
  assign waddr = count[AW-1:0];
  assign wdata = c;

  // store contents as they stand after this byte
  assign b0n = (wr && count == CW'(0)) ? c : b0;
  assign s1n = (wr && count == CW'(1)) ? c : s1;
  assign s2n = (wr && count == CW'(2)) ? c : s2;

  always_comb begin
    for (int i = 0; i < MATCH_BYTES; i++) begin
      mbn[i] = (wr && count == CW'(4 + i)) ? c : mb[i];
      mbv[i] = (4 + i < MAX_BYTES) ? mbn[i] : 8'h00;
    end
  end

  assign len_ext   = {1'b0, mbn[0]};
  assign cnt_ext   = 9'(cnt1);
  assign hit_bad   = (cnt_ext == len_ext + 9'd6) && (sum1 != 8'h00);
  assign hit_end   = (cnt_ext == len_ext + 9'd7);
  assign filt_miss = cfg.enable && (s1n != cfg.unit) && (s2n != cfg.unit);

  always_comb begin
    if (c == NAK_BYTE) begin
      ack_code = ACK_NAK;
    end else if (c == ACK_BYTE) begin
      ack_code = ACK_OK;
    end else begin
      ack_code = ACK_MISS;
    end
  end

  // first matching template wins
  always_comb begin
    logic hit;
    fmt = FMT_UNKNOWN;
    for (int t = NUM_TPL - 1; t >= 0; t--) begin
      hit = 1'b1;
      for (int i = 0; i < MATCH_BYTES && i < TPL_W; i++) begin
        if (i < int'(TPL_LEN[t]) && mbv[i] != TPL_VAL[t][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        fmt = 5'(t);
      end
    end
  end

  always_comb begin
    count_next    = count;
    sum_next      = sum;
    skip_next     = skip;
    supp_next     = supp;
    b0_next       = b0n;
    run_wait_next = run_wait & ~run_done;
    supp1         = supp;
    push          = 1'b0;
    push_desc     = '{kind: KIND_GOOD, val: c, n: N_W'(cnt1), b0: b0n, src: s1n,
                      dst: s2n, fmt: FMT_UNKNOWN, ack: ACK_OK};
    if (accept) begin
      if (in_ch.command == CMD_IDLE) begin
        count_next = '0;
        sum_next   = '0;
        skip_next  = 1'b0;
        supp_next  = 1'b0;
      end else begin
        sum_next   = sum1;
        count_next = cnt1;
        if (!room && !skip) begin
          push           = 1'b1;
          push_desc.kind = KIND_OVF;
          skip_next      = 1'b1;
        end else if (!skip) begin
          supp1     = supp | ((cnt1 == CW'(4)) & filt_miss);
          supp_next = supp1;
          if (cnt1 >= CW'(5)) begin
            if (hit_bad) begin
              push           = 1'b1;
              push_desc.kind = KIND_BAD;
              skip_next      = 1'b1;
              sum_next       = '0;
              run_wait_next  = 1'b1;
            end else if (hit_end) begin
              push           = ~supp1;
              push_desc.fmt  = fmt;
              push_desc.ack  = ack_code;
              run_wait_next  = ~supp1;
              supp_next      = 1'b0;
              sum_next       = '0;
              count_next     = '0;
              // missing acknowledge opens the next packet
              if (ack_code == ACK_MISS) begin
                b0_next    = c;
                count_next = CW'(1);
                sum_next   = c;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      skip     <= 1'b0;
      supp     <= 1'b0;
      run_wait <= 1'b0;
    end else begin
      count    <= count_next;
      sum      <= sum_next;
      skip     <= skip_next;
      supp     <= supp_next;
      run_wait <= run_wait_next;
    end
  end

  always_ff @(posedge clk) begin
    b0 <= b0_next;
    s1 <= s1n;
    s2 <= s2n;
    for (int i = 0; i < MATCH_BYTES; i++) begin
      mb[i] <= mbn[i];
    end
  end

endmodule

### rtl/core/hbpd_back.sv
// hbpd_back: emitter that plays queued runs out of the byte store
// into the output register; uses hbpd_pkg and hbpd_out_if

module hbpd_back import hbpd_pkg::*; #(
  parameter int MAX_BYTES = 20,
  localparam int AW = $clog2(MAX_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  desc_t         q_desc,
  output logic          pop,
  output logic          re,
  output logic [AW-1:0] raddr,
  input  logic [7:0]    rdata,
  output logic          run_done,
  hbpd_out_if.source    out_ch
);

  localparam int CW = $clog2(MAX_BYTES + 1);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_FETCH  = 4'b0010,
    B_LOAD   = 4'b0100,
    B_SINGLE = 4'b1000
  } bstate_t;

  bstate_t       state;
  desc_t         cur;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic          is_last;
  logic          out_free;
  logic          load_run;
  logic          load_one;

  logic       out_valid;
  logic [1:0] o_kind;
  logic [7:0] o_value;
  logic [4:0] o_index;
  logic       o_last;
  logic [7:0] o_src;
  logic [7:0] o_dst;
  logic [4:0] o_fmt;
  logic [1:0] o_ack;

  assign out_free = ~out_valid | out_ch.ready;
  assign pop      = (state == B_IDLE) & q_valid;
  assign re       = (state == B_FETCH);
  assign raddr    = idx[AW-1:0];
  assign idx_inc  = idx + 1'b1;
  assign is_last  = (idx_inc == cur.n[CW-1:0]);
  assign load_run = (state == B_LOAD) & out_free;
  assign load_one = (state == B_SINGLE) & out_free;
  assign run_done = load_run & is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_run || load_one) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= (q_desc.kind == KIND_OVF) ? B_SINGLE : B_FETCH;
          end
        end
        B_FETCH: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          if (out_free) begin
            state <= is_last ? B_IDLE : B_FETCH;
          end
        end
        B_SINGLE: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_desc;
      idx <= '0;
    end else if (load_run && !is_last) begin
      idx <= idx_inc;
    end
    if (load_run || load_one) begin
      o_kind <= cur.kind;
      o_src  <= cur.src;
      o_dst  <= cur.dst;
      o_fmt  <= cur.fmt;
      o_ack  <= cur.ack;
    end
    if (load_run) begin
      // byte 0 travels with the run, the store may already hold the next packet
      o_value <= (idx == '0) ? cur.b0 : rdata;
      o_index <= 5'(idx);
      o_last  <= is_last;
    end else if (load_one) begin
      o_value <= cur.val;
      o_index <= 5'(MAX_BYTES);
      o_last  <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.event_kind  = o_kind;
  assign out_ch.byte_value  = o_value;
  assign out_ch.byte_index  = o_index;
  assign out_ch.last        = o_last;
  assign out_ch.source_addr = o_src;
  assign out_ch.dest_addr   = o_dst;
  assign out_ch.format_code = o_fmt;
  assign out_ch.ack_status  = o_ack;

endmodule

### rtl/core/hvac_bus_packet_deframer_unit.sv
// hvac_bus_packet_deframer_unit: top level of the bus packet deframer
// uses hbpd_pkg, hbpd_if, hbpd_ram, hbpd_fifo, hbpd_front, hbpd_back
//
//   channel  | kind      | transfer when        | payload
//   ---------+-----------+----------------------+------------------------------------
//   in_ch    | sink      | valid & ready        | command, rx_byte
//   out_ch   | source    | valid & ready        | event_kind .. ack_status, one per byte
//   apb      | cfg slave | psel&penable&pwrite  | filter enable @0x0, unit address @0x4
//
// a byte or idle gap is taken while the queue is not full and no run is outstanding
// a run of n bytes is taken from the queue, then each byte gets a store read and an output load;
// input is held off from the byte that ends a packet until its last byte is loaded
// an overflow result is taken from the queue and loaded as one output; it does not hold off input
// synchronous reset clears the framer, the queue, the emitter and the configuration; the byte store is not cleared
// output stalls back up into the queue, then into ready

module hvac_bus_packet_deframer_unit import hbpd_pkg::*; #(
  parameter int MAX_BYTES = 20,
  parameter int MATCH_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  hbpd_in_if.sink     in_ch,
  hbpd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int QUEUE_DEPTH = 2;

  cfg_t          cfg;
  logic          cfg_wr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          push;
  desc_t         push_desc;
  logic          q_full;
  logic          pop;
  desc_t         q_desc;
  logic          q_valid;
  logic          run_done;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{enable: 1'b0, unit: 8'h00};
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FILTER_ENABLE: cfg.enable <= pwdata[0];
        REG_UNIT_ADDR:     cfg.unit   <= pwdata[7:0];
        default:           cfg        <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_ENABLE: prdata = {31'b0, cfg.enable};
      REG_UNIT_ADDR:     prdata = {24'b0, cfg.unit};
      default:           prdata = '0;
    endcase
  end

  hbpd_front #(
    .MAX_BYTES   (MAX_BYTES),
    .MATCH_BYTES (MATCH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full),
    .run_done  (run_done)
  );

  hbpd_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_desc),
    .not_empty (q_valid)
  );

  hbpd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  hbpd_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .pop      (pop),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .run_done (run_done),
    .out_ch   (out_ch)
  );

endmodule

### rtl/core/hbpd_checker.sv
// hbpd_checker: port level checks of the deframer, bound to the top level
// uses hbpd_pkg; attached by the bind statement at the end of this file

module hbpd_checker import hbpd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic       last,
  input logic [4:0] format_code,
  input logic [1:0] ack_status
);

  // a result waits until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered out of reset");

  // overflow is a single result with no format and no acknowledge
  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_OVF |->
      last && format_code == FMT_UNKNOWN && ack_status == ACK_OK)
    else $error("malformed overflow result");

  // bad checksum runs carry no format and no acknowledge
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_BAD |->
      format_code == FMT_UNKNOWN && ack_status == ACK_OK)
    else $error("malformed bad checksum result");

endmodule

bind hvac_bus_packet_deframer_unit hbpd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_kind  (out_ch.event_kind),
  .last        (out_ch.last),
  .format_code (out_ch.format_code),
  .ack_status  (out_ch.ack_status)
);
